// File: hw/rtl/sgb_pkg.sv
// ----------------------------------------------------------------------------
// sgb_pkg
// Shared types, constants and helpers for the separable Gaussian blur unit.
// ----------------------------------------------------------------------------
package sgb_pkg;

  localparam int MAX_RADIUS = 4;
  localparam int WIN_DEPTH  = 2 * MAX_RADIUS + 1;
  localparam int MAX_WIDTH  = 256;
  localparam int ROW_LIMIT  = 256;
  localparam int NUM_CH     = 4;
  localparam int CH_W       = 16;
  localparam int PIX_W      = NUM_CH * CH_W;
  localparam int WGT_W      = 17;
  localparam int PROD_W     = WGT_W + CH_W;
  localparam int ACC_W      = PROD_W + 4;
  localparam int SLOT_W     = 4;
  localparam int COORD_W    = 8;
  localparam int DIM_W      = 9;
  localparam int RAD_W      = 3;
  localparam int TAP_W      = 4;
  localparam int LS_AW      = SLOT_W + COORD_W;
  localparam int LS_DEPTH   = WIN_DEPTH * MAX_WIDTH;
  localparam int OUT_W      = 2 * COORD_W + PIX_W;
  localparam int Q_DEPTH    = 2;
  localparam int Q_CNT_W    = 2;

  // Register map, in word order
  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_RADIUS = 3'd2,
    REG_W0     = 3'd3,
    REG_W1     = 3'd4,
    REG_W2     = 3'd5,
    REG_W3     = 3'd6,
    REG_W4     = 3'd7
  } reg_idx_t;

  // One classified item, passed from front to back
  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [SLOT_W-1:0]  cslot;
    logic [SLOT_W-1:0]  rslot;
    logic [COORD_W-1:0] xlo;
    logic [COORD_W-1:0] xhi;
    logic               has_x;
    logic [COORD_W-1:0] ylo;
    logic [COORD_W-1:0] yhi;
    logic               has_y;
    logic [RAD_W-1:0]   rad;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_H_ISSUE,
    ST_H_WAIT,
    ST_V_ISSUE,
    ST_V_WAIT,
    ST_EMIT
  } back_state_t;

  // Slot of an entry d places behind slot, modulo WIN_DEPTH (d below WIN_DEPTH)
  function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] slot,
                                                  input logic [SLOT_W-1:0] d);
    logic [SLOT_W:0] s;
    if (slot >= d) begin
      s = {1'b0, slot} - {1'b0, d};
    end else begin
      s = {1'b0, slot} + (SLOT_W+1)'(WIN_DEPTH) - {1'b0, d};
    end
    return s[SLOT_W-1:0];
  endfunction

  // Round Q5.32 sum to Q0.16 and saturate
  function automatic logic [CH_W-1:0] round_sat(input logic [ACC_W-1:0] acc);
    logic [ACC_W-1:0] t;
    t = acc + ACC_W'(32768);
    if (|t[ACC_W-1:2*CH_W]) begin
      return {CH_W{1'b1}};
    end
    return t[2*CH_W-1:CH_W];
  endfunction

endpackage

// File: hw/rtl/sgb_front.sv
// ----------------------------------------------------------------------------
// sgb_front
// Accepts pixels, tracks column and row, and works out which horizontal and
// vertical results each pixel makes computable.
// ----------------------------------------------------------------------------
module sgb_front import sgb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [PIX_W-1:0] in_tdata,
  input  logic [DIM_W-1:0] image_width,
  input  logic [DIM_W-1:0] image_height,
  input  logic [RAD_W-1:0] filter_radius,
  input  logic             q_full,
  output logic             push,
  output cmd_t             cmd
);

  logic [COORD_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [SLOT_W-1:0]  cslot_r, cslot_nxt, rslot_r, rslot_nxt;
  logic [DIM_W-1:0]   wd, ht;
  logic [RAD_W-1:0]   rad;
  logic               row_end, frame_end, c_ge, r_ge;
  logic [COORD_W-1:0] c_lo, r_lo;

  // Clamp configuration into range
  always_comb begin
    wd  = (image_width == '0) ? DIM_W'(1) :
          (image_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : image_width;
    ht  = (image_height == '0) ? DIM_W'(1) :
          (image_height > DIM_W'(ROW_LIMIT)) ? DIM_W'(ROW_LIMIT) : image_height;
    rad = (filter_radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : filter_radius;
  end

  // Classify the item
  always_comb begin
    row_end   = {1'b0, col_r} >= (wd - DIM_W'(1));
    frame_end = {1'b0, row_r} >= (ht - DIM_W'(1));
    c_ge      = col_r >= COORD_W'(rad);
    r_ge      = row_r >= COORD_W'(rad);
    c_lo      = c_ge ? col_r - COORD_W'(rad) : '0;
    r_lo      = r_ge ? row_r - COORD_W'(rad) : '0;

    cmd.pixel = in_tdata;
    cmd.col   = col_r;
    cmd.row   = row_r;
    cmd.cslot = cslot_r;
    cmd.rslot = rslot_r;
    cmd.xlo   = c_lo;
    cmd.xhi   = row_end ? col_r : c_lo;
    cmd.has_x = row_end | c_ge;
    cmd.ylo   = r_lo;
    cmd.yhi   = frame_end ? row_r : r_lo;
    cmd.has_y = frame_end | r_ge;
    cmd.rad   = rad;
  end

  assign in_tready = !q_full;
  assign push      = in_tvalid & !q_full;

  // Advance position counters
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    cslot_nxt = cslot_r;
    rslot_nxt = rslot_r;
    if (push) begin
      if (row_end) begin
        col_nxt   = '0;
        cslot_nxt = '0;
        if (frame_end) begin
          row_nxt   = '0;
          rslot_nxt = '0;
        end else begin
          row_nxt   = row_r + COORD_W'(1);
          rslot_nxt = (rslot_r == SLOT_W'(WIN_DEPTH - 1)) ? '0 : rslot_r + SLOT_W'(1);
        end
      end else begin
        col_nxt   = col_r + COORD_W'(1);
        cslot_nxt = (cslot_r == SLOT_W'(WIN_DEPTH - 1)) ? '0 : cslot_r + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      cslot_r <= '0;
      rslot_r <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      cslot_r <= cslot_nxt;
      rslot_r <= rslot_nxt;
    end
  end

endmodule

// File: hw/rtl/sgb_queue.sv
// ----------------------------------------------------------------------------
// sgb_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module sgb_queue import sgb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  cmd_t               wdata,
  input  logic               pop,
  output cmd_t               rdata,
  output logic               empty,
  output logic               full,
  output logic [Q_CNT_W-1:0] count
);

  cmd_t               ent_r [Q_DEPTH];
  logic               wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign count = cnt_r;
  assign rdata = ent_r[rptr_r];

  // Move pointers and fill level
  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + Q_CNT_W'(push) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Hold entries
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= wdata;
    end
  end

endmodule

// File: hw/rtl/sgb_back.sv
// ----------------------------------------------------------------------------
// sgb_back
// Sequencer for the horizontal and vertical passes: row window, line store,
// a four-lane multiply-accumulate pipe and the output register.
// ----------------------------------------------------------------------------
module sgb_back import sgb_pkg::*; (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  input  cmd_t                            q_head,
  output logic                            pop,
  input  logic [MAX_RADIUS:0][WGT_W-1:0]  weights,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [OUT_W-1:0]                out_tdata,
  output logic                            out_tlast
);

  back_state_t        state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [COORD_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [TAP_W-1:0]   k_r, k_nxt;

  logic [PIX_W-1:0]   win_r [WIN_DEPTH];
  logic [PIX_W-1:0]   ls_mem [LS_DEPTH];

  logic               iss_v, iss_src, win_we, ls_we, out_load, out_free;
  logic [TAP_W-1:0]   k_end, tap_dist;
  logic signed [COORD_W+2:0] hpos, vpos;
  logic [COORD_W-1:0] hcl, vcl, hd, vd;
  logic [SLOT_W-1:0]  win_idx, vslot;
  logic [LS_AW-1:0]   ls_waddr, ls_raddr;

  // Pipe registers
  logic               s1_v_r, s1_src_r, s1_first_r, s1_last_r;
  logic [PIX_W-1:0]   win_q_r, ls_q_r, op1;
  logic [WGT_W-1:0]   wgt_r;
  logic               s2_v_r, s2_first_r, s2_last_r, done_r;
  logic [PROD_W-1:0]  prod_r [NUM_CH];
  logic [ACC_W-1:0]   acc_r [NUM_CH];
  logic [PIX_W-1:0]   res;

  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r;
  logic               out_last_r;

  assign k_end    = {cmd_r.rad, 1'b0};
  assign tap_dist = (k_r >= TAP_W'(cmd_r.rad)) ? k_r - TAP_W'(cmd_r.rad)
                                               : TAP_W'(cmd_r.rad) - k_r;

  // Clamp tap positions to the edges, then find their slots
  always_comb begin
    hpos = $signed({3'b0, x_r}) + $signed({{(COORD_W-1){1'b0}}, k_r})
         - $signed({{(COORD_W){1'b0}}, cmd_r.rad});
    vpos = $signed({3'b0, y_r}) + $signed({{(COORD_W-1){1'b0}}, k_r})
         - $signed({{(COORD_W){1'b0}}, cmd_r.rad});
    if (hpos < 0) begin
      hcl = '0;
    end else if (hpos > $signed({3'b0, cmd_r.col})) begin
      hcl = cmd_r.col;
    end else begin
      hcl = hpos[COORD_W-1:0];
    end
    if (vpos < 0) begin
      vcl = '0;
    end else if (vpos > $signed({3'b0, cmd_r.row})) begin
      vcl = cmd_r.row;
    end else begin
      vcl = vpos[COORD_W-1:0];
    end
    hd       = cmd_r.col - hcl;
    vd       = cmd_r.row - vcl;
    win_idx  = slot_back(cmd_r.cslot, hd[SLOT_W-1:0]);
    vslot    = slot_back(cmd_r.rslot, vd[SLOT_W-1:0]);
    ls_raddr = {vslot, x_r};
    ls_waddr = {cmd_r.rslot, x_r};
  end

  // Round all four lanes
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      res[ch*CH_W +: CH_W] = round_sat(acc_r[ch]);
    end
  end

  assign out_free = !out_valid_r || out_tready;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    k_nxt     = k_r;
    pop       = 1'b0;
    iss_v     = 1'b0;
    iss_src   = 1'b0;
    win_we    = 1'b0;
    ls_we     = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          pop     = 1'b1;
          win_we  = 1'b1;
          cmd_nxt = q_head;
          x_nxt   = q_head.xlo;
          k_nxt   = '0;
          if (q_head.has_x) begin
            state_nxt = ST_H_ISSUE;
          end
        end
      end
      ST_H_ISSUE: begin
        iss_v = 1'b1;
        if (k_r == k_end) begin
          k_nxt     = '0;
          state_nxt = ST_H_WAIT;
        end else begin
          k_nxt = k_r + TAP_W'(1);
        end
      end
      ST_H_WAIT: begin
        if (done_r) begin
          ls_we = 1'b1;
          if (cmd_r.has_y) begin
            y_nxt     = cmd_r.ylo;
            state_nxt = ST_V_ISSUE;
          end else if (x_r < cmd_r.xhi) begin
            x_nxt     = x_r + COORD_W'(1);
            state_nxt = ST_H_ISSUE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_V_ISSUE: begin
        iss_v   = 1'b1;
        iss_src = 1'b1;
        if (k_r == k_end) begin
          k_nxt     = '0;
          state_nxt = ST_V_WAIT;
        end else begin
          k_nxt = k_r + TAP_W'(1);
        end
      end
      ST_V_WAIT: begin
        if (done_r) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (y_r < cmd_r.yhi) begin
            y_nxt     = y_r + COORD_W'(1);
            state_nxt = ST_V_ISSUE;
          end else if (x_r < cmd_r.xhi) begin
            x_nxt     = x_r + COORD_W'(1);
            state_nxt = ST_H_ISSUE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
  end

  // Row window
  always_ff @(posedge clk) begin
    if (win_we) begin
      win_r[q_head.cslot] <= q_head.pixel;
    end
  end

  // Line store
  always_ff @(posedge clk) begin
    if (ls_we) begin
      ls_mem[ls_waddr] <= res;
    end
    ls_q_r <= ls_mem[ls_raddr];
  end

  // Tap fetch, multiply, accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      s1_v_r <= iss_v;
      s2_v_r <= s1_v_r;
      done_r <= s2_v_r & s2_last_r;
    end
  end

  assign op1 = s1_src_r ? ls_q_r : win_q_r;

  always_ff @(posedge clk) begin
    win_q_r    <= win_r[win_idx];
    wgt_r      <= weights[tap_dist[RAD_W-1:0]];
    s1_src_r   <= iss_src;
    s1_first_r <= (k_r == '0);
    s1_last_r  <= (k_r == k_end);
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      prod_r[ch] <= wgt_r * op1[ch*CH_W +: CH_W];
      if (s2_v_r) begin
        acc_r[ch] <= s2_first_r ? ACC_W'(prod_r[ch]) : acc_r[ch] + ACC_W'(prod_r[ch]);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {res, y_r, x_r};
      out_last_r <= (x_r == cmd_r.xhi) && (y_r == cmd_r.yhi);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// File: hw/rtl/separable_gaussian_blur_unit.sv
// ----------------------------------------------------------------------------
// separable_gaussian_blur_unit
// Streaming RGBA Gaussian blur with clamp-to-edge borders, one pass.
// ----------------------------------------------------------------------------
// Pixels enter in raster order and are accepted while the two-entry queue
// has room. The back end works through one pixel at a time: it writes the
// pixel to the row window, then for each horizontal result issues 2R+1
// taps to the multiply-accumulate pipe and writes the sum to the line
// store, and for each blurred pixel issues 2R+1 line-store reads and loads
// the sum into the output register once that is free. Both passes share
// the single multiply-accumulate pipe; the next pixel leaves the queue only
// once the current one is through. Results carry their column and row;
// tlast marks the last result caused by an input pixel.
module separable_gaussian_blur_unit import sgb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [PIX_W-1:0]  in_tdata,   // red_in, green_in, blue_in, alpha_in
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,  // out_column, out_row, red_out,
                                        // green_out, blue_out, alpha_out
  output logic              out_tlast,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [DIM_W-1:0]               width_r, height_r;
  logic [RAD_W-1:0]               radius_r;
  logic [MAX_RADIUS:0][WGT_W-1:0] wgt_r;
  logic                           wr_en;
  reg_idx_t                       widx;

  logic               push, pop, q_empty, q_full;
  logic [Q_CNT_W-1:0] q_count;
  cmd_t               f_cmd, q_head;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign widx   = reg_idx_t'(paddr[4:2]);

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(256);
      height_r <= DIM_W'(256);
      radius_r <= RAD_W'(2);
      wgt_r    <= {{MAX_RADIUS{WGT_W'(0)}}, WGT_W'(65536)};
    end else if (wr_en) begin
      case (widx)
        REG_WIDTH:  width_r  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_r <= pwdata[DIM_W-1:0];
        REG_RADIUS: radius_r <= pwdata[RAD_W-1:0];
        REG_W0:     wgt_r[0] <= pwdata[WGT_W-1:0];
        REG_W1:     wgt_r[1] <= pwdata[WGT_W-1:0];
        REG_W2:     wgt_r[2] <= pwdata[WGT_W-1:0];
        REG_W3:     wgt_r[3] <= pwdata[WGT_W-1:0];
        REG_W4:     wgt_r[4] <= pwdata[WGT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (widx)
      REG_WIDTH:  prdata = 32'(width_r);
      REG_HEIGHT: prdata = 32'(height_r);
      REG_RADIUS: prdata = 32'(radius_r);
      REG_W0:     prdata = 32'(wgt_r[0]);
      REG_W1:     prdata = 32'(wgt_r[1]);
      REG_W2:     prdata = 32'(wgt_r[2]);
      REG_W3:     prdata = 32'(wgt_r[3]);
      REG_W4:     prdata = 32'(wgt_r[4]);
      default:    prdata = '0;
    endcase
  end

  sgb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .image_width   (width_r),
    .image_height  (height_r),
    .filter_radius (radius_r),
    .q_full        (q_full),
    .push          (push),
    .cmd           (f_cmd)
  );

  sgb_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (f_cmd),
    .pop   (pop),
    .rdata (q_head),
    .empty (q_empty),
    .full  (q_full),
    .count (q_count)
  );

  sgb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .pop        (pop),
    .weights    (wgt_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Queue never overfills and back pressure follows its level
  a_q_level: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= Q_CNT_W'(Q_DEPTH))
    else $error("queue level out of range");

  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (q_count != Q_CNT_W'(Q_DEPTH)))
    else $error("input ready disagrees with queue level");

  // Nothing popped from an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("pop from empty queue");

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

// File: sim/separable_gaussian_blur_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// separable_gaussian_blur_unit_tb
// Streams RGBA frames through the blur unit under a series of register
// settings and compares every blurred pixel with a behavioural predictor.
// ----------------------------------------------------------------------------
// Each setting is written while the unit is idle, then whole frames follow,
// bar one mid-row width change; the line store is only ever read where the current frame wrote it.
// Both stream sides idle in short random bursts; one phase holds the result
// side off for a long stretch so the unit backs up into its input.
// ----------------------------------------------------------------------------
module separable_gaussian_blur_unit_tb;
  import sgb_pkg::*;

  typedef struct {
    bit [7:0]  column;
    bit [7:0]  row;
    bit [63:0] pixel;
    bit        last;
  } blurred_px_t;

  // Predictor of the blur and store of pending blurred pixels
  class blur_scoreboard;
    bit [8:0]    width_reg;
    bit [8:0]    height_reg;
    bit [2:0]    radius_reg;
    bit [16:0]   weight[5];
    bit [63:0]   row_window[WIN_DEPTH];
    bit [63:0]   line_store[WIN_DEPTH * MAX_WIDTH];
    int          column_pos;
    int          row_pos;
    blurred_px_t pending_px[$];
    int          errors;

    function void reset_state();
      width_reg  = 256;
      height_reg = 256;
      radius_reg = 2;
      weight[0]  = 65536;
      for (int i = 1; i < 5; i++) weight[i] = 0;
      for (int i = 0; i < WIN_DEPTH; i++) row_window[i] = '0;
      column_pos = 0;
      row_pos    = 0;
      errors     = 0;
    endfunction

    function void set_reg(reg_idx_t idx, bit [31:0] value);
      case (idx)
        REG_WIDTH:  width_reg  = value[8:0];
        REG_HEIGHT: height_reg = value[8:0];
        REG_RADIUS: radius_reg = value[2:0];
        default:    weight[idx - REG_W0] = value[16:0];
      endcase
    endfunction

    // Weighted sum per channel, rounded and saturated to Q0.16
    function bit [63:0] weigh_taps(bit [63:0] taps[WIN_DEPTH], int rad);
      bit [63:0] res;
      bit [63:0] acc;
      res = '0;
      for (int ch = 0; ch < 4; ch++) begin
        acc = 0;
        for (int k = 0; k <= 2 * rad; k++)
          acc += 64'(weight[(k > rad) ? k - rad : rad - k]) * 64'(taps[k][16*ch +: 16]);
        acc = (acc + 64'd32768) >> 16;
        if (acc > 64'd65535) acc = 64'd65535;
        res[16*ch +: 16] = acc[15:0];
      end
      return res;
    endfunction

    function int clip(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Advance the predictor by one accepted pixel
    function void note_pixel(bit [63:0] pix);
      bit [63:0]   taps[WIN_DEPTH];
      blurred_px_t res;
      int wd, ht, rad, c, r, xlo, xhi, ylo, yhi, n0;
      bit row_end, frame_end;
      wd  = clip(width_reg, 1, MAX_WIDTH);
      ht  = clip(height_reg, 1, ROW_LIMIT);
      rad = (radius_reg > MAX_RADIUS) ? MAX_RADIUS : radius_reg;
      c   = column_pos;
      r   = row_pos;
      n0  = pending_px.size();
      row_window[c % WIN_DEPTH] = pix;
      row_end   = c >= wd - 1;
      frame_end = r >= ht - 1;
      if (row_end) begin
        xlo = (c >= rad) ? c - rad : 0;
        xhi = c;
      end else if (c >= rad) begin
        xlo = c - rad;
        xhi = c - rad;
      end else begin
        xlo = 0;
        xhi = -1;
      end
      for (int x = xlo; x <= xhi; x++) begin
        for (int k = 0; k <= 2 * rad; k++)
          taps[k] = row_window[clip(x + k - rad, 0, c) % WIN_DEPTH];
        line_store[(r % WIN_DEPTH) * MAX_WIDTH + x] = weigh_taps(taps, rad);
        // the last row of a frame flushes the rest of its column
        if (frame_end) begin
          ylo = (r >= rad) ? r - rad : 0;
          yhi = r;
        end else if (r >= rad) begin
          ylo = r - rad;
          yhi = r - rad;
        end else begin
          ylo = 0;
          yhi = -1;
        end
        for (int y = ylo; y <= yhi; y++) begin
          for (int k = 0; k <= 2 * rad; k++)
            taps[k] = line_store[(clip(y + k - rad, 0, r) % WIN_DEPTH) * MAX_WIDTH + x];
          res.column = x[7:0];
          res.row    = y[7:0];
          res.pixel  = weigh_taps(taps, rad);
          res.last   = 0;
          pending_px.push_back(res);
        end
      end
      if (pending_px.size() > n0) pending_px[pending_px.size() - 1].last = 1;
      if (row_end) begin
        column_pos = 0;
        row_pos    = frame_end ? 0 : r + 1;
      end else begin
        column_pos = c + 1;
      end
    endfunction

    // Compare one accepted result with the oldest pending pixel
    function void check_result(bit [OUT_W-1:0] data, bit last);
      blurred_px_t exp_px;
      if (pending_px.size() == 0) begin
        $display("%0t: unexpected result: actual %h last %b", $time, data, last);
        errors++;
        return;
      end
      exp_px = pending_px.pop_front();
      if (data[7:0] !== exp_px.column)
        begin $display("%0t: column: expected %0d actual %0d", $time, exp_px.column,
                       data[7:0]); errors++; end
      if (data[15:8] !== exp_px.row)
        begin $display("%0t: row: expected %0d actual %0d", $time, exp_px.row,
                       data[15:8]); errors++; end
      for (int ch = 0; ch < 4; ch++)
        if (data[16 + 16*ch +: 16] !== exp_px.pixel[16*ch +: 16]) begin
          $display("%0t: channel %0d at (%0d,%0d): expected %h actual %h", $time, ch,
                   exp_px.column, exp_px.row, exp_px.pixel[16*ch +: 16],
                   data[16 + 16*ch +: 16]);
          errors++;
        end
      if (last !== exp_px.last)
        begin $display("%0t: tlast: expected %b actual %b", $time, exp_px.last, last);
              errors++; end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [PIX_W-1:0]  in_tdata;   // red_in, green_in, blue_in, alpha_in
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;  // out_column, out_row, red_out, green_out,
                                 // blue_out, alpha_out
  logic              out_tlast;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [4:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  blur_scoreboard sb;
  bit  quiet;      // no idling in the closing part
  bit  hold_req;   // ask the result side for one long hold-off
  int  idle_cnt;
  int  sent;

  localparam int WATCHDOG_LIMIT = 4000;

  separable_gaussian_blur_unit i_dut (.*);

  always #5 clk = ~clk;

  // Result side: random stalls, one long hold on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 0;
      out_tready <= 1'b0;
      repeat (400) @(posedge clk);
    end
    if (idle_cnt > 0) begin
      idle_cnt--;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      idle_cnt = $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Check results mid-cycle, when both handshake signals are settled
  always @(negedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);

  // Abort when nothing moves for too long
  int stuck;
  always @(negedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) stuck = 0;
    else stuck++;
    if (stuck >= WATCHDOG_LIMIT) begin
      $display("separable_gaussian_blur_unit_tb: FAIL");
      $finish;
    end
  end

  // Write one register over the configuration port
  task automatic write_reg(reg_idx_t idx, bit [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(4 * idx);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  task automatic set_frame(bit [31:0] wd, bit [31:0] ht, bit [31:0] rad);
    write_reg(REG_WIDTH, wd);
    write_reg(REG_HEIGHT, ht);
    write_reg(REG_RADIUS, rad);
  endtask

  task automatic set_weights(bit [31:0] w0, bit [31:0] w1, bit [31:0] w2,
                             bit [31:0] w3, bit [31:0] w4);
    write_reg(REG_W0, w0);
    write_reg(REG_W1, w1);
    write_reg(REG_W2, w2);
    write_reg(REG_W3, w3);
    write_reg(REG_W4, w4);
  endtask

  // Offer one pixel, with an optional random gap first; returns at the
  // rising edge at which it is taken
  task automatic send_pixel(bit [63:0] pix);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    do @(negedge clk); while (!in_tready);
    sb.note_pixel(pix);
    sent++;
    @(posedge clk);
  endtask

  // Stop offering and wait until every pending pixel has come out
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_px.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic bit [63:0] rand_pixel();
    return {$urandom, $urandom};
  endfunction

  function automatic bit [31:0] rand_weight();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 65536;
      default: return $urandom_range(0, 32768);
    endcase
  endfunction

  task automatic send_frames(int frames);
    int wd, ht;
    wd = (sb.width_reg == 0) ? 1 : ((sb.width_reg > MAX_WIDTH) ? MAX_WIDTH : sb.width_reg);
    ht = (sb.height_reg == 0) ? 1 : ((sb.height_reg > ROW_LIMIT) ? ROW_LIMIT : sb.height_reg);
    repeat (frames * wd * ht) send_pixel(rand_pixel());
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    clk       = 0;
    rst_n     = 0;
    in_tvalid = 0;
    in_tdata  = '0;
    out_tready = 0;
    psel      = 0;
    penable   = 0;
    pwrite    = 0;
    paddr     = '0;
    pwdata    = '0;
    quiet     = 0;
    hold_req  = 0;
    idle_cnt  = 0;
    sent      = 0;
    stuck     = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero width and height, radius past the maximum, full weights: 1x1
    // frames that saturate
    set_frame(0, 0, 7);
    set_weights(65536, 65536, 65536, 65536, 65536);
    send_pixel(64'h0);
    send_pixel(64'hFFFF_FFFF_FFFF_FFFF);
    send_pixel(64'hAAAA_5555_0000_FFFF);
    send_pixel(64'h5555_AAAA_FFFF_0001);
    drain();

    // Small 4x3 frame with a three-tap kernel
    set_frame(4, 3, 1);
    set_weights(32768, 16384, 0, 0, 0);
    send_pixel(64'hFFFF_FFFF_FFFF_FFFF);
    send_pixel(64'h0);
    repeat (10) send_pixel(rand_pixel());
    drain();

    // Width lowered mid-row on a one-row frame: the current column ends it
    set_frame(10, 1, 4);
    set_weights(rand_weight(), rand_weight(), rand_weight(), rand_weight(), rand_weight());
    repeat (6) send_pixel(rand_pixel());
    drain();
    write_reg(REG_WIDTH, 3);
    send_pixel(rand_pixel());
    drain();

    // Oversized width: one full 256-pixel row
    set_frame(511, 1, 4);
    set_weights(rand_weight(), rand_weight(), rand_weight(), rand_weight(), rand_weight());
    send_frames(1);
    drain();

    // Random settings; one phase backs up behind a long result hold-off,
    // with a single-tap kernel so every pixel makes a result at once
    for (int ph = 0; sent < 470; ph++) begin
      if (sent > 400) quiet = 1;
      if (ph == 1) begin
        set_frame(12, 8, 0);
      end else begin
        set_frame($urandom_range(1, 12), $urandom_range(1, 8),
                  ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4));
      end
      set_weights(rand_weight(), rand_weight(), rand_weight(), rand_weight(), rand_weight());
      if (ph == 1) hold_req = 1;
      send_frames($urandom_range(1, 2));
      drain();
    end

    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending_px.size() == 0)
      $display("separable_gaussian_blur_unit_tb: PASS");
    else
      $display("separable_gaussian_blur_unit_tb: FAIL");
    $finish;
  end

endmodule
